>>> rtl/i2cm_pkg.sv
// i2cm_pkg: item types, command codes and sequencer step codes for the
// I2C master register-access block. No dependencies.
`default_nettype none

package i2cm_pkg;

    // Input item, one per transfer on the input channel
    typedef struct packed {
        logic [2:0]  func;
        logic        sda_sample;
        logic [6:0]  slave_address;
        logic [15:0] register_address;
        logic        address_wide;
        logic [15:0] byte_count;
        logic [7:0]  write_byte;
    } t_in_item;

    // Result item, one per accepted input item
    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        busy_res;
        logic        byte_request;
        logic [7:0]  read_data;
        logic        read_valid;
        logic        read_last;
        logic        transfer_done;
        logic        acknowledged;
    } t_out_item;

    // Command codes
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_WRITE = 3'd1;
    localparam logic [2:0] FUNC_READ  = 3'd2;
    localparam logic [2:0] FUNC_PROBE = 3'd3;
    localparam logic [2:0] FUNC_LOAD  = 3'd4;

    // Transfer kinds (low bits of the begin command)
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_PROBE = 2'd3;

    // Byte roles; a byte step is {role, phase}
    localparam logic [2:0] ROLE_ADDR_W = 3'd0;
    localparam logic [2:0] ROLE_REG_HI = 3'd1;
    localparam logic [2:0] ROLE_REG_LO = 3'd2;
    localparam logic [2:0] ROLE_ADDR_R = 3'd3;
    localparam logic [2:0] ROLE_DATA   = 3'd4;

    // Phases within a transmitted byte
    localparam logic [2:0] PH_TXL   = 3'd0;
    localparam logic [2:0] PH_TXH   = 3'd1;
    localparam logic [2:0] PH_AREL  = 3'd2;
    localparam logic [2:0] PH_ACLK  = 3'd3;
    localparam logic [2:0] PH_APOLL = 3'd4;

    // Stand-alone steps
    localparam logic [5:0] S_IDLE   = 6'd40;
    localparam logic [5:0] S_START1 = 6'd41;
    localparam logic [5:0] S_START2 = 6'd42;
    localparam logic [5:0] S_START3 = 6'd43;
    localparam logic [5:0] S_RST1   = 6'd44;
    localparam logic [5:0] S_RST2   = 6'd45;
    localparam logic [5:0] S_RST3   = 6'd46;
    localparam logic [5:0] S_WAIT   = 6'd47;
    localparam logic [5:0] S_RXL    = 6'd48;
    localparam logic [5:0] S_RXH    = 6'd49;
    localparam logic [5:0] S_RACK1  = 6'd50;
    localparam logic [5:0] S_RACK2  = 6'd51;
    localparam logic [5:0] S_RACK3  = 6'd52;
    localparam logic [5:0] S_STOP1  = 6'd53;
    localparam logic [5:0] S_STOP2  = 6'd54;
    localparam logic [5:0] S_STOP3  = 6'd55;

endpackage

`default_nettype wire

>>> rtl/i2cm_seq.sv
// i2cm_seq: bus sequencer state and its combinational next-state/result logic.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_seq #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire i2cm_pkg::t_in_item  i_item,
    input  wire logic [7:0]          i_poll_limit,
    output i2cm_pkg::t_out_item      o_result
);
    import i2cm_pkg::*;

    logic [5:0]            r_step,    n_step;
    logic [2:0]            r_bit,     n_bit;
    logic [7:0]            r_shift,   n_shift;
    logic [COUNT_BITS-1:0] r_bytes,   n_bytes;
    logic [7:0]            r_poll,    n_poll;
    logic [6:0]            r_target,  n_target;
    logic [15:0]           r_regword, n_regword;
    logic                  r_wide,    n_wide;
    logic [1:0]            r_kind,    n_kind;
    logic [7:0]            r_pend,    n_pend;
    logic                  r_pend_v,  n_pend_v;
    logic                  r_status,  n_status;
    logic                  r_scl,     n_scl;
    logic                  r_sda,     n_sda;

    logic [2:0] role;
    logic [2:0] phase;
    logic       tx_bit;
    logic       do_next;
    logic [7:0] rx_byte;
    logic [7:0] rdata;
    logic       rvalid;
    logic       rlast;
    logic       done;

    assign role    = r_step[5:3];
    assign phase   = r_step[2:0];
    assign tx_bit  = r_shift[7];
    assign rx_byte = {r_shift[6:0], i_item.sda_sample};

    always_comb begin
        n_step    = r_step;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_bytes   = r_bytes;
        n_poll    = r_poll;
        n_target  = r_target;
        n_regword = r_regword;
        n_wide    = r_wide;
        n_kind    = r_kind;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_status  = r_status;
        n_scl     = r_scl;
        n_sda     = r_sda;
        do_next   = 1'b0;
        rdata     = 8'h00;
        rvalid    = 1'b0;
        rlast     = 1'b0;
        done      = 1'b0;

        if (i_accept) begin
            case (i_item.func)
                FUNC_LOAD: begin
                    n_pend   = i_item.write_byte;
                    n_pend_v = 1'b1;
                end
                FUNC_WRITE, FUNC_READ, FUNC_PROBE: begin
                    if (r_step == S_IDLE) begin
                        n_kind    = i_item.func[1:0];
                        n_target  = i_item.slave_address;
                        n_regword = i_item.register_address;
                        n_wide    = i_item.address_wide;
                        n_bytes   = (i_item.func == FUNC_PROBE) ? '0
                                    : i_item.byte_count[COUNT_BITS-1:0];
                        n_pend_v  = 1'b0;
                        n_status  = 1'b1;
                        n_poll    = 8'h00;
                        n_bit     = 3'd0;
                        n_step    = S_START1;
                    end
                end
                FUNC_TICK: begin
                    if (r_step < S_IDLE && phase <= PH_APOLL) begin
                        case (phase)
                            PH_TXL: begin
                                n_scl  = 1'b0;
                                n_sda  = tx_bit;
                                n_step = {role, PH_TXH};
                            end
                            PH_TXH: begin
                                n_scl   = 1'b1;
                                n_sda   = tx_bit;
                                n_shift = {r_shift[6:0], 1'b0};
                                if (r_bit == 3'd7) begin
                                    n_bit  = 3'd0;
                                    n_step = {role, PH_AREL};
                                end else begin
                                    n_bit  = r_bit + 3'd1;
                                    n_step = {role, PH_TXL};
                                end
                            end
                            PH_AREL: begin
                                n_scl  = 1'b0;
                                n_sda  = 1'b1;
                                n_step = {role, PH_ACLK};
                            end
                            PH_ACLK: begin
                                n_scl  = 1'b1;
                                n_sda  = 1'b1;
                                n_poll = 8'h00;
                                n_step = {role, PH_APOLL};
                            end
                            default: begin
                                if (!i_item.sda_sample) begin
                                    // acknowledged: pick the next byte of the transfer, or go to STOP
                                    n_scl = 1'b0;
                                    n_sda = 1'b1;
                                    case (role)
                                        ROLE_ADDR_W: begin
                                            if (r_kind == KIND_PROBE) begin
                                                n_step = S_STOP1;
                                            end else if (r_wide) begin
                                                n_shift = r_regword[15:8];
                                                n_bit   = 3'd0;
                                                n_step  = {ROLE_REG_HI, PH_TXL};
                                            end else begin
                                                n_shift = r_regword[7:0];
                                                n_bit   = 3'd0;
                                                n_step  = {ROLE_REG_LO, PH_TXL};
                                            end
                                        end
                                        ROLE_REG_HI: begin
                                            n_shift = r_regword[7:0];
                                            n_bit   = 3'd0;
                                            n_step  = {ROLE_REG_LO, PH_TXL};
                                        end
                                        ROLE_REG_LO: begin
                                            if (r_kind == KIND_READ) begin
                                                n_step = S_RST1;
                                            end else begin
                                                do_next = 1'b1;
                                            end
                                        end
                                        ROLE_ADDR_R: begin
                                            if (r_bytes != '0) begin
                                                n_shift = 8'h00;
                                                n_bit   = 3'd0;
                                                n_step  = S_RXL;
                                            end else begin
                                                n_step = S_STOP1;
                                            end
                                        end
                                        default: begin
                                            do_next = 1'b1;
                                        end
                                    endcase
                                end else if (r_poll >= i_poll_limit) begin
                                    // timeout: hold SCL low, then STOP
                                    n_scl    = 1'b0;
                                    n_sda    = 1'b1;
                                    n_status = 1'b0;
                                    n_step   = S_STOP1;
                                end else begin
                                    n_scl  = 1'b1;
                                    n_sda  = 1'b1;
                                    n_poll = r_poll + 8'd1;
                                end
                            end
                        endcase
                    end else begin
                        case (r_step)
                            S_START1, S_RST1: begin
                                n_scl  = 1'b1;
                                n_sda  = 1'b1;
                                n_step = r_step + 6'd1;
                            end
                            S_START2, S_RST2: begin
                                n_scl  = 1'b1;
                                n_sda  = 1'b0;
                                n_step = r_step + 6'd1;
                            end
                            S_START3: begin
                                n_scl   = 1'b0;
                                n_sda   = 1'b0;
                                n_shift = {r_target, 1'b0};
                                n_bit   = 3'd0;
                                n_step  = {ROLE_ADDR_W, PH_TXL};
                            end
                            S_RST3: begin
                                n_scl   = 1'b0;
                                n_sda   = 1'b0;
                                n_shift = {r_target, 1'b1};
                                n_bit   = 3'd0;
                                n_step  = {ROLE_ADDR_R, PH_TXL};
                            end
                            S_WAIT: begin
                                n_scl   = 1'b0;
                                n_sda   = 1'b1;
                                do_next = 1'b1;
                            end
                            S_RXL: begin
                                n_scl  = 1'b0;
                                n_sda  = 1'b1;
                                n_step = S_RXH;
                            end
                            S_RXH: begin
                                n_scl   = 1'b1;
                                n_sda   = 1'b1;
                                n_shift = rx_byte;
                                if (r_bit == 3'd7) begin
                                    n_bit   = 3'd0;
                                    rvalid  = 1'b1;
                                    rdata   = rx_byte;
                                    rlast   = (r_bytes == COUNT_BITS'(1));
                                    n_bytes = r_bytes - COUNT_BITS'(1);
                                    n_step  = S_RACK1;
                                end else begin
                                    n_bit  = r_bit + 3'd1;
                                    n_step = S_RXL;
                                end
                            end
                            S_RACK1, S_RACK2, S_RACK3: begin
                                // ACK while bytes remain, NACK after the last
                                n_scl = (r_step == S_RACK2);
                                n_sda = (r_bytes == '0);
                                if (r_step != S_RACK3) begin
                                    n_step = r_step + 6'd1;
                                end else if (r_bytes != '0) begin
                                    n_shift = 8'h00;
                                    n_step  = S_RXL;
                                end else begin
                                    n_step = S_STOP1;
                                end
                            end
                            S_STOP1: begin
                                n_scl  = 1'b0;
                                n_sda  = 1'b0;
                                n_step = S_STOP2;
                            end
                            S_STOP2: begin
                                n_scl  = 1'b1;
                                n_sda  = 1'b0;
                                n_step = S_STOP3;
                            end
                            S_STOP3: begin
                                n_scl  = 1'b1;
                                n_sda  = 1'b1;
                                done   = 1'b1;
                                n_step = S_IDLE;
                            end
                            default: begin
                                n_scl  = 1'b1;
                                n_sda  = 1'b1;
                                n_step = S_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase

            // next data byte: stop, send the loaded byte, or wait for one
            if (do_next) begin
                if (r_bytes == '0) begin
                    n_step = S_STOP1;
                end else if (r_pend_v) begin
                    n_bytes  = r_bytes - COUNT_BITS'(1);
                    n_pend_v = 1'b0;
                    n_shift  = r_pend;
                    n_bit    = 3'd0;
                    n_step   = {ROLE_DATA, PH_TXL};
                end else begin
                    n_step = S_WAIT;
                end
            end
        end
    end

    always_comb begin
        o_result.scl_level     = n_scl;
        o_result.sda_level     = n_sda;
        o_result.busy_res      = (n_step != S_IDLE);
        o_result.byte_request  = (n_step == S_WAIT) && !n_pend_v;
        o_result.read_data     = rdata;
        o_result.read_valid    = rvalid;
        o_result.read_last     = rlast;
        o_result.transfer_done = done;
        o_result.acknowledged  = done & r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= S_IDLE;
            r_bit    <= 3'd0;
            r_bytes  <= '0;
            r_poll   <= 8'h00;
            r_wide   <= 1'b0;
            r_kind   <= 2'd0;
            r_pend_v <= 1'b0;
            r_status <= 1'b1;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
        end else begin
            r_step   <= n_step;
            r_bit    <= n_bit;
            r_bytes  <= n_bytes;
            r_poll   <= n_poll;
            r_wide   <= n_wide;
            r_kind   <= n_kind;
            r_pend_v <= n_pend_v;
            r_status <= n_status;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
        end
    end

    // payload: always written before it is read
    always_ff @(posedge i_clk) begin
        r_shift   <= n_shift;
        r_target  <= n_target;
        r_regword <= n_regword;
        r_pend    <= n_pend;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_WAIT) |-> (r_kind != KIND_READ && r_kind != KIND_PROBE))
        else $error("write-data wait reached in a read or probe");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_RXL || r_step == S_RXH) |-> (r_bytes != '0))
        else $error("receiving with no bytes left");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.func == FUNC_TICK && r_step == S_STOP3) |=>
        (r_step == S_IDLE && r_scl && r_sda))
        else $error("STOP did not release the bus");

endmodule

`default_nettype wire

>>> rtl/i2c_master_register_access.sv
// i2c_master_register_access: top level, I2C master register-access sequencer
// with config register and output skid buffer. Depends on i2cm_pkg, i2cm_seq.
`default_nettype none

//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+------------------------
//  input    | i_in_valid, o_in_stall, i_in_data        | i_in_valid && !o_in_stall
//  output   | o_out_valid, i_out_stall, o_out_data     | o_out_valid && !i_out_stall
//  config   | i_cfg_we, i_cfg_wdata (ack_poll_limit)   | i_cfg_we
//
// One item per cycle while o_in_stall is low: each command or tick is one step
// of the sequencer, computed in one pass from the state registers and registered
// into the output register, or into the skid register while the output is stalled.
// Throughput is set by the output slot pair: stall rises only when both the
// output register and the skid register hold results.
// Reset (i_rst_n low at a clock edge) idles the bus with SCL and SDA released,
// empties both output slots and sets ack_poll_limit to 255.

module i2c_master_register_access #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire i2cm_pkg::t_in_item   i_in_data,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      i2cm_pkg::t_out_item  o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [7:0]           i_cfg_wdata
);
    import i2cm_pkg::*;

    logic [7:0] r_poll_limit;
    logic       r_out_valid;
    t_out_item  r_out_data;
    logic       r_skid_valid;
    t_out_item  r_skid_data;

    logic       in_take;
    logic       out_free;
    t_out_item  result;

    // stall comes straight from a register, never from i_in_valid
    assign o_in_stall  = r_skid_valid;
    assign in_take     = i_in_valid && !r_skid_valid;
    // output slot can be loaded: empty, or its result leaves this edge
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    i2cm_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_take),
        .i_item       (i_in_data),
        .i_poll_limit (r_poll_limit),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= 8'hFF;
        end else if (i_cfg_we) begin
            r_poll_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_take;
            end
        end else if (in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : result;
        end
        if (!out_free && in_take) begin
            r_skid_data <= result;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full while output slot empty");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && !r_skid_valid && in_take) |=> r_skid_valid)
        else $error("result dropped while output stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.read_last) |-> r_out_data.read_valid)
        else $error("last-byte flag without received byte");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.transfer_done) |->
        (!r_out_data.busy_res && r_out_data.scl_level && r_out_data.sda_level))
        else $error("transfer done while bus not released");

endmodule

`default_nettype wire
